// File: src/wps_pkg.sv
package wps_pkg;

    // Geometry of the history ring
    localparam int WINDOW  = 10;
    localparam int ANGLES  = 5;
    localparam int NFIELDS = 5;

    localparam int DATA_W  = 16;
    localparam int FB_W    = 15;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int ANG_W   = $clog2(NFIELDS);
    localparam int DEPTH   = WINDOW * ANGLES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * DATA_W;

    // Sum of up to WINDOW signed 16-bit values; its magnitude fits in 20 bits
    localparam int SUM_W   = 21;
    localparam int MAG_W   = 20;

    // Reciprocal scaling: q = (mag * ceil(2^K / d)) >> K is exact for
    // mag < 2^20 and d <= 16 once K >= 24.
    localparam int RECIP_K = 24;
    localparam int RECIP_W = 25;
    localparam int RIDX_W  = 5;
    localparam int PROD_W  = MAG_W + RECIP_W;

    // Configuration register map
    localparam int            REG_IDX_W      = 1;
    localparam logic [REG_IDX_W-1:0] REG_FALLBACK = 1'b0;
    localparam logic [FB_W-1:0]      FALLBACK_RESET = 15'd3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SUM   = 7'b0000010,
        S_MULF  = 7'b0000100,
        S_BLDF  = 7'b0001000,
        S_BLDA  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef logic signed [DATA_W-1:0] sample_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [RIDX_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592406;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355444;
            5'd6:    r = 25'd2796203;
            5'd7:    r = 25'd2396746;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864136;
            5'd10:   r = 25'd1677722;
            5'd11:   r = 25'd1525202;
            5'd12:   r = 25'd1398102;
            5'd13:   r = 25'd1290556;
            5'd14:   r = 25'd1198373;
            5'd15:   r = 25'd1118482;
            5'd16:   r = 25'd1048576;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] u;
        u = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        return u[MAG_W-1:0];
    endfunction

    // Apply sign to the truncated average, add the current value, halve toward zero
    function automatic sample_t blend(input logic [MAG_W-1:0] q, input logic neg,
                                      input sample_t cur);
        logic signed [SUM_W-1:0] avg;
        logic signed [SUM_W-1:0] s;
        avg = signed'(SUM_W'(q));
        if (neg) begin
            avg = -avg;
        end
        s = avg + SUM_W'(cur);
        if (s < 0) begin
            s = s + SUM_W'(1);
        end
        return sample_t'(s[DATA_W:1]);
    endfunction

endpackage

// File: src/wps_ram.sv
module wps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/windowed_parameter_smoother_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_freq_0..4, s_amp_0..4 (signed Q8.8)
// m_        out        m_valid / m_ready   m_smoothed_freq_0..4, m_smoothed_amp_0..4,
//                                          m_master_freq, m_applied
// apb       in/out     psel/penable/pready paddr, pwdata, prdata (fallback_frequency)
//
// An item is handled one angle at a time: for each angle the block sums the held snapshots
// (1..WINDOW) read from the history, then multiplies and blends freq and amp; last, it
// writes the raw snapshot back. The first item skips the sums. The single read port of the
// history RAM, one entry per cycle, and the shared reciprocal multiplier set the pace.
// Reset (aresetn low, synchronous) empties the history and restores fallback to 3.
// A result waiting in the output register holds the next item in its last step.
module windowed_parameter_smoother_unit
    import wps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_freq_0,
    input  logic signed [15:0]  s_freq_1,
    input  logic signed [15:0]  s_freq_2,
    input  logic signed [15:0]  s_freq_3,
    input  logic signed [15:0]  s_freq_4,
    input  logic signed [15:0]  s_amp_0,
    input  logic signed [15:0]  s_amp_1,
    input  logic signed [15:0]  s_amp_2,
    input  logic signed [15:0]  s_amp_3,
    input  logic signed [15:0]  s_amp_4,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_smoothed_freq_0,
    output logic signed [15:0]  m_smoothed_freq_1,
    output logic signed [15:0]  m_smoothed_freq_2,
    output logic signed [15:0]  m_smoothed_freq_3,
    output logic signed [15:0]  m_smoothed_freq_4,
    output logic signed [15:0]  m_smoothed_amp_0,
    output logic signed [15:0]  m_smoothed_amp_1,
    output logic signed [15:0]  m_smoothed_amp_2,
    output logic signed [15:0]  m_smoothed_amp_3,
    output logic signed [15:0]  m_smoothed_amp_4,
    output logic [14:0]         m_master_freq,
    output logic                m_applied,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       held_reg, held_next;       // snapshots in the history
    logic [ADDR_W-1:0]      wbase_reg, wbase_next;     // first address of write slot
    logic                   m_valid_reg, m_valid_next;
    logic [FB_W-1:0]        fallback_reg, fallback_next;
    logic                   pend_reg, pend_next;       // RAM read in flight

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    sample_t                raw_f_reg [NFIELDS];
    sample_t                raw_m_reg [NFIELDS];
    sample_t                raw_f_next [NFIELDS];
    sample_t                raw_m_next [NFIELDS];
    sample_t                sf_reg [NFIELDS];
    sample_t                sm_reg [NFIELDS];
    sample_t                sf_next [NFIELDS];
    sample_t                sm_next [NFIELDS];
    sample_t                out_f_reg [NFIELDS];
    sample_t                out_m_reg [NFIELDS];
    sample_t                out_f_next [NFIELDS];
    sample_t                out_m_next [NFIELDS];
    logic [FB_W-1:0]        out_master_reg, out_master_next;
    logic                   out_applied_reg, out_applied_next;
    logic                   applied_reg, applied_next;
    sample_t                best_reg, best_next;
    logic [ANG_W-1:0]       angle_reg, angle_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]      raddr_reg, raddr_next;
    logic signed [SUM_W-1:0] fsum_reg, fsum_next;
    logic signed [SUM_W-1:0] asum_reg, asum_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;

    sample_t                in_f [NFIELDS];
    sample_t                in_m [NFIELDS];

    // History RAM port
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [MAG_W-1:0]       mul_a;
    logic [RECIP_W-1:0]     mul_b;
    logic [MAG_W-1:0]       quot;
    sample_t                blend_res;
    logic                   blend_neg;
    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   cfg_idx;
    logic                   s_accept;
    logic                   last_angle;

    assign in_f[0] = s_freq_0;
    assign in_f[1] = s_freq_1;
    assign in_f[2] = s_freq_2;
    assign in_f[3] = s_freq_3;
    assign in_f[4] = s_freq_4;
    assign in_m[0] = s_amp_0;
    assign in_m[1] = s_amp_1;
    assign in_m[2] = s_amp_2;
    assign in_m[3] = s_amp_3;
    assign in_m[4] = s_amp_4;

    // ---------------------------------------------------------------
    // Configuration port: one register, fallback_frequency at offset 0
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        fallback_next = fallback_reg;
        if (cfg_write && cfg_idx == REG_FALLBACK) begin
            fallback_next = pwdata[FB_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FALLBACK: prdata = 32'(fallback_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // History store: one entry per (slot, angle), {freq, amp}
    // ---------------------------------------------------------------
    wps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == S_WRITE);
    assign ram_waddr = wbase_reg + ADDR_W'(angle_reg);
    assign ram_wdata = {raw_f_reg[angle_reg], raw_m_reg[angle_reg]};

    // ---------------------------------------------------------------
    // Shared divide-by-count unit: one multiplier by a reciprocal table
    // ---------------------------------------------------------------
    assign mul_a     = (state_reg == S_MULF) ? magnitude(fsum_reg) : magnitude(asum_reg);
    assign mul_b     = recip(RIDX_W'(held_reg));
    assign quot      = prod_reg[RECIP_K +: MAG_W];
    assign blend_neg = (state_reg == S_BLDF) ? fsum_reg[SUM_W-1] : asum_reg[SUM_W-1];
    assign blend_res = blend(quot, blend_neg,
                             (state_reg == S_BLDF) ? raw_f_reg[angle_reg]
                                                   : raw_m_reg[angle_reg]);

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign last_angle = (angle_reg == ANG_W'(ANGLES - 1));

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        held_next        = held_reg;
        wbase_next       = wbase_reg;
        m_valid_next     = m_valid_reg;
        pend_next        = 1'b0;
        raw_f_next       = raw_f_reg;
        raw_m_next       = raw_m_reg;
        sf_next          = sf_reg;
        sm_next          = sm_reg;
        out_f_next       = out_f_reg;
        out_m_next       = out_m_reg;
        out_master_next  = out_master_reg;
        out_applied_next = out_applied_reg;
        applied_next     = applied_reg;
        best_next        = best_reg;
        angle_next       = angle_reg;
        idx_next         = idx_reg;
        raddr_next       = raddr_reg;
        fsum_next        = fsum_reg;
        asum_next        = asum_reg;
        prod_next        = prod_reg;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    // Capture the snapshot; unused angles simply echo
                    raw_f_next   = in_f;
                    raw_m_next   = in_m;
                    sf_next      = in_f;
                    sm_next      = in_m;
                    applied_next = (held_reg != '0);
                    best_next    = '0;
                    angle_next   = '0;
                    idx_next     = '0;
                    raddr_next   = '0;
                    fsum_next    = '0;
                    asum_next    = '0;
                    state_next   = (held_reg != '0) ? S_SUM : S_WRITE;
                end
            end
            S_SUM: begin
                // Issue one read per held slot, stride ANGLES
                if (idx_reg != held_reg) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    raddr_next = raddr_reg + ADDR_W'(ANGLES);
                    pend_next  = 1'b1;
                end
                if (pend_reg) begin
                    fsum_next = fsum_reg + SUM_W'(sample_t'(ram_rdata[ENTRY_W-1 -: DATA_W]));
                    asum_next = asum_reg + SUM_W'(sample_t'(ram_rdata[DATA_W-1:0]));
                end
                if (idx_reg == held_reg && !pend_reg) begin
                    state_next = S_MULF;
                end
            end
            S_MULF: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_BLDF;
            end
            S_BLDF: begin
                sf_next[angle_reg] = blend_res;
                prod_next          = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next         = S_BLDA;
            end
            S_BLDA: begin
                sm_next[angle_reg] = blend_res;
                if (sf_reg[angle_reg] > best_reg) begin
                    best_next = sf_reg[angle_reg];
                end
                if (last_angle) begin
                    angle_next = '0;
                    state_next = S_WRITE;
                end else begin
                    angle_next = angle_reg + ANG_W'(1);
                    raddr_next = ADDR_W'(angle_reg) + ADDR_W'(1);
                    idx_next   = '0;
                    fsum_next  = '0;
                    asum_next  = '0;
                    state_next = S_SUM;
                end
            end
            S_WRITE: begin
                // Store the raw snapshot, one angle per cycle
                if (last_angle) begin
                    angle_next = '0;
                    if (wbase_reg == ADDR_W'(DEPTH - ANGLES)) begin
                        wbase_next = '0;
                    end else begin
                        wbase_next = wbase_reg + ADDR_W'(ANGLES);
                    end
                    if (held_reg != CNT_W'(WINDOW)) begin
                        held_next = held_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end else begin
                    angle_next = angle_reg + ANG_W'(1);
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_f_next       = sf_reg;
                    out_m_next       = sm_reg;
                    out_applied_next = applied_reg;
                    if (!applied_reg) begin
                        out_master_next = '0;
                    end else if (best_reg > 0) begin
                        out_master_next = best_reg[FB_W-1:0];
                    end else begin
                        out_master_next = fallback_reg;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            wbase_reg    <= '0;
            m_valid_reg  <= 1'b0;
            fallback_reg <= FALLBACK_RESET;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            wbase_reg    <= wbase_next;
            m_valid_reg  <= m_valid_next;
            fallback_reg <= fallback_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_f_reg       <= raw_f_next;
        raw_m_reg       <= raw_m_next;
        sf_reg          <= sf_next;
        sm_reg          <= sm_next;
        out_f_reg       <= out_f_next;
        out_m_reg       <= out_m_next;
        out_master_reg  <= out_master_next;
        out_applied_reg <= out_applied_next;
        applied_reg     <= applied_next;
        best_reg        <= best_next;
        angle_reg       <= angle_next;
        idx_reg         <= idx_next;
        raddr_reg       <= raddr_next;
        fsum_reg        <= fsum_next;
        asum_reg        <= asum_next;
        prod_reg        <= prod_next;
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign m_valid           = m_valid_reg;
    assign m_smoothed_freq_0 = out_f_reg[0];
    assign m_smoothed_freq_1 = out_f_reg[1];
    assign m_smoothed_freq_2 = out_f_reg[2];
    assign m_smoothed_freq_3 = out_f_reg[3];
    assign m_smoothed_freq_4 = out_f_reg[4];
    assign m_smoothed_amp_0  = out_m_reg[0];
    assign m_smoothed_amp_1  = out_m_reg[1];
    assign m_smoothed_amp_2  = out_m_reg[2];
    assign m_smoothed_amp_3  = out_m_reg[3];
    assign m_smoothed_amp_4  = out_m_reg[4];
    assign m_master_freq     = out_master_reg;
    assign m_applied         = out_applied_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(WINDOW))
        else $error("history count beyond window");

    a_first_master: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_applied |-> m_master_freq == '0)
        else $error("master frequency set on first snapshot");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SUM && idx_reg != held_reg |-> raddr_reg < ADDR_W'(DEPTH))
        else $error("history read address out of range");

endmodule

// File: tb/tb.sv
module tb;
    import wps_pkg::*;

    // Sender gaps and receiver stalls are drawn per item from this range
    localparam int GAP_MAX       = 17;
    // Longest correct quiet stretch: sender gap + full-window item + stall
    localparam int STALL_LIMIT   = 3000;
    // Drain time at the end, a bit more than one full-window item
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 255;

    // Register map: fallback_frequency at index 0; index 1 has no register
    localparam logic [2:0] FALLBACK_ADDR = {REG_FALLBACK, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    typedef logic [NFIELDS-1:0][DATA_W-1:0] lane_t;

    typedef struct packed {
        lane_t freq;
        lane_t amp;
    } snapshot_t;

    typedef struct packed {
        lane_t           freq;
        lane_t           amp;
        logic [FB_W-1:0] master;
        logic            applied;
    } smoothed_t;

    // Flavors of random snapshot runs
    typedef enum int {
        STYLE_DRIFT,
        STYLE_FULL,
        STYLE_EXTREME,
        STYLE_NEGATIVE,
        STYLE_NEAR_ZERO,
        STYLE_MIXED
    } style_t;

    // Clock, reset and block inputs, all known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        m_ready  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    snapshot_t   shown_snap = '0;

    wire                         s_ready;
    wire                         m_valid;
    wire [NFIELDS-1:0][DATA_W-1:0] out_freq;
    wire [NFIELDS-1:0][DATA_W-1:0] out_amp;
    wire [FB_W-1:0]              out_master;
    wire                         out_applied;
    wire [31:0]                  prdata;
    wire                         pready;

    // Handshake flags captured at the rising edge, read by the falling-edge drivers
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    // Snapshots waiting to be sent, and smoothed results still to come back
    snapshot_t snapshot_queue[$];
    smoothed_t smoothed_due[$];
    bit        snapshot_shown = 1'b0;

    // Our own copy of the history ring and the fallback register
    int              freq_hist[WINDOW][ANGLES];
    int              amp_hist[WINDOW][ANGLES];
    int              snapshots_held = 0;
    int              next_slot      = 0;
    logic [FB_W-1:0] fallback_hz    = FALLBACK_RESET;

    // Random stimulus shaping
    int     drift_freq[NFIELDS] = '{512, 600, 700, 800, 900};
    int     drift_amp[NFIELDS]  = '{1000, 1200, 1400, 1600, 1800};
    style_t run_style = STYLE_DRIFT;
    int     run_left  = 0;

    int  snap_gap    = 0;
    int  ready_gap   = 0;
    bit  send_burst  = 1'b0;
    bit  take_burst  = 1'b0;
    int  idle_cycles = 0;
    int  fail_count  = 0;

    windowed_parameter_smoother_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_freq_0          (shown_snap.freq[0]),
        .s_freq_1          (shown_snap.freq[1]),
        .s_freq_2          (shown_snap.freq[2]),
        .s_freq_3          (shown_snap.freq[3]),
        .s_freq_4          (shown_snap.freq[4]),
        .s_amp_0           (shown_snap.amp[0]),
        .s_amp_1           (shown_snap.amp[1]),
        .s_amp_2           (shown_snap.amp[2]),
        .s_amp_3           (shown_snap.amp[3]),
        .s_amp_4           (shown_snap.amp[4]),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_smoothed_freq_0 (out_freq[0]),
        .m_smoothed_freq_1 (out_freq[1]),
        .m_smoothed_freq_2 (out_freq[2]),
        .m_smoothed_freq_3 (out_freq[3]),
        .m_smoothed_freq_4 (out_freq[4]),
        .m_smoothed_amp_0  (out_amp[0]),
        .m_smoothed_amp_1  (out_amp[1]),
        .m_smoothed_amp_2  (out_amp[2]),
        .m_smoothed_amp_3  (out_amp[3]),
        .m_smoothed_amp_4  (out_amp[4]),
        .m_master_freq     (out_master),
        .m_applied         (out_applied),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Append one snapshot to the send queue
    task automatic enqueue_snapshot(input snapshot_t snap);
        snapshot_queue = {snapshot_queue, snap};
    endtask

    // Mean of the held history (truncated toward zero), then halve with the current value
    function automatic int window_blend(input int sum, input int cur);
        int avg;
        avg = sum / snapshots_held;
        return (avg + cur) / 2;
    endfunction

    // Predict the result of one snapshot, then store the snapshot in our history ring
    function automatic smoothed_t smooth_snapshot(input snapshot_t snap);
        smoothed_t r;
        int        cur_f[ANGLES];
        int        cur_a[ANGLES];
        int        sum_f;
        int        sum_a;
        int        sf;
        int        best;
        int        a;
        int        i;
        best      = 0;
        r.freq    = snap.freq;
        r.amp     = snap.amp;
        r.master  = '0;
        r.applied = (snapshots_held > 0);
        for (a = 0; a < ANGLES; a++) begin
            cur_f[a] = $signed(snap.freq[a]);
            cur_a[a] = $signed(snap.amp[a]);
        end
        // The very first snapshot only echoes its inputs
        if (snapshots_held > 0) begin
            for (a = 0; a < ANGLES; a++) begin
                sum_f = 0;
                sum_a = 0;
                for (i = 0; i < snapshots_held; i++) begin
                    sum_f += freq_hist[i][a];
                    sum_a += amp_hist[i][a];
                end
                sf        = window_blend(sum_f, cur_f[a]);
                r.freq[a] = DATA_W'(sf);
                r.amp[a]  = DATA_W'(window_blend(sum_a, cur_a[a]));
                if (sf > best) begin
                    best = sf;
                end
            end
            // A smoothed frequency of exactly zero does not count as positive
            r.master = (best > 0) ? FB_W'(best) : fallback_hz;
        end
        for (a = 0; a < ANGLES; a++) begin
            freq_hist[next_slot][a] = cur_f[a];
            amp_hist[next_slot][a]  = cur_a[a];
        end
        next_slot = (next_slot + 1) % WINDOW;
        if (snapshots_held < WINDOW) begin
            snapshots_held++;
        end
        return r;
    endfunction

    function automatic snapshot_t uniform_snapshot(input logic [DATA_W-1:0] f,
                                                   input logic [DATA_W-1:0] m);
        snapshot_t s;
        int        a;
        for (a = 0; a < NFIELDS; a++) begin
            s.freq[a] = f;
            s.amp[a]  = m;
        end
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] random_value(input style_t style, input int drift);
        case (style)
            STYLE_DRIFT: begin
                return DATA_W'(drift + int'($urandom_range(0, 64)) - 32);
            end
            STYLE_FULL: begin
                return DATA_W'($urandom);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            STYLE_NEGATIVE: begin
                return {1'b1, 15'($urandom)};
            end
            default: begin
                return DATA_W'(int'($urandom_range(0, 8)) - 4);
            end
        endcase
    endfunction

    // Snapshots come in runs of one flavor so the window fills with like data:
    // drifting signals most often, the rest wild, extreme, negative, near zero or mixed
    function automatic snapshot_t random_snapshot();
        snapshot_t s;
        style_t    fs;
        int        a;
        if (run_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_style = STYLE_DRIFT;
                4:          run_style = STYLE_FULL;
                5:          run_style = STYLE_EXTREME;
                6, 7:       run_style = STYLE_NEGATIVE;
                8:          run_style = STYLE_NEAR_ZERO;
                default:    run_style = STYLE_MIXED;
            endcase
            run_left = $urandom_range(1, 12);
        end
        run_left--;
        for (a = 0; a < NFIELDS; a++) begin
            drift_freq[a] += int'($urandom_range(0, 400)) - 200;
            drift_amp[a]  += int'($urandom_range(0, 400)) - 200;
            if (drift_freq[a] > 32000 || drift_freq[a] < -32000) begin
                drift_freq[a] = 512;
            end
            if (drift_amp[a] > 32000 || drift_amp[a] < -32000) begin
                drift_amp[a] = 1000;
            end
            fs = (run_style == STYLE_MIXED) ? style_t'($urandom_range(0, 4)) : run_style;
            s.freq[a] = random_value(fs, drift_freq[a]);
            s.amp[a]  = random_value((fs == STYLE_NEGATIVE) ? STYLE_FULL : fs, drift_amp[a]);
        end
        return s;
    endfunction

    // APB write: setup cycle, access cycle, register takes the data at the access edge
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FALLBACK_ADDR) begin
            fallback_hz = data[FB_W-1:0];
        end
    endtask

    // APB read of the fallback register, checked against our copy
    task automatic reg_check(input logic [2:0] addr);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(fallback_hz)) begin
            report_error($sformatf("fallback read: got %0d expected %0d", got, fallback_hz));
        end
    endtask

    // Hold off until every queued snapshot is sent and every result is back
    task automatic wait_drained();
        while (snapshot_queue.size() != 0 || snapshot_shown || smoothed_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Sender: present one snapshot at a time, hold it until taken, then idle a drawn gap
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_took) begin
                snapshot_shown = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                snap_gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!snapshot_shown) begin
                if (snap_gap > 0) begin
                    snap_gap--;
                end else if (snapshot_queue.size() > 0) begin
                    shown_snap     <= snapshot_queue.pop_front();
                    snapshot_shown = 1'b1;
                end
            end
            s_valid <= snapshot_shown;
        end
    end

    // Receiver: after each result, drop ready for a drawn number of cycles
    always @(negedge aclk) begin
        if (m_took) begin
            if ($urandom_range(0, 39) == 0) begin
                take_burst = !take_burst;
            end
            ready_gap = take_burst ? 0 : $urandom_range(0, GAP_MAX);
        end
        if (ready_gap > 0) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted snapshot, check every accepted result
    always @(posedge aclk) begin : monitor
        smoothed_t want;
        int        a;
        s_took <= aresetn && s_valid && s_ready;
        m_took <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            smoothed_due = {smoothed_due, smooth_snapshot(shown_snap)};
        end
        if (aresetn && m_valid && m_ready) begin
            if (smoothed_due.size() == 0) begin
                report_error("result arrived with no snapshot outstanding");
            end else begin
                want = smoothed_due.pop_front();
                for (a = 0; a < NFIELDS; a++) begin
                    if (out_freq[a] !== want.freq[a]) begin
                        report_error($sformatf("smoothed_freq_%0d: got %0d expected %0d", a,
                                     $signed(out_freq[a]), $signed(want.freq[a])));
                    end
                    if (out_amp[a] !== want.amp[a]) begin
                        report_error($sformatf("smoothed_amp_%0d: got %0d expected %0d", a,
                                     $signed(out_amp[a]), $signed(want.amp[a])));
                    end
                end
                if (out_master !== want.master) begin
                    report_error($sformatf("master_freq: got %0d expected %0d",
                                 out_master, want.master));
                end
                if (out_applied !== want.applied) begin
                    report_error($sformatf("applied: got %0b expected %0b",
                                 out_applied, want.applied));
                end
            end
        end
    end

    // Watchdog: any handshake or register access counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int              phase;
        int              n;
        logic [FB_W-1:0] fb;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register comes out of reset at its default
        reg_check(FALLBACK_ADDR);

        // First snapshot after reset: echoed, not applied; fields at their extremes
        enqueue_snapshot('{freq: {16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF},
                           amp:  {16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}});
        enqueue_snapshot(uniform_snapshot(16'h7FFF, 16'h7FFF));
        enqueue_snapshot(uniform_snapshot(16'h8000, 16'h8000));
        enqueue_snapshot(uniform_snapshot(16'h7FFF, 16'h8000));
        enqueue_snapshot(uniform_snapshot(16'h8000, 16'h7FFF));
        // Flush the window with zeros: the ring wraps and every smoothed frequency
        // ends at zero, so the master falls back to the reset fallback
        repeat (11) enqueue_snapshot(uniform_snapshot(16'h0000, 16'h0000));
        // Halving toward zero on small odd values
        enqueue_snapshot(uniform_snapshot(16'hFFFF, 16'hFFFF));
        enqueue_snapshot(uniform_snapshot(16'h0001, 16'h0001));
        enqueue_snapshot(uniform_snapshot(16'hFFFD, 16'h0003));
        wait_drained();

        // Random phases, each under its own fallback; the block is idle between them
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       fb = '0;
                1:       fb = '1;
                3:       fb = 15'd1;
                5:       fb = 15'h4000;
                default: fb = 15'($urandom);
            endcase
            // Upper data bits are random and must be dropped by the register
            reg_write(FALLBACK_ADDR, ($urandom & ~32'h7FFF) | 32'(fb));
            reg_check(FALLBACK_ADDR);
            if (phase == 3) begin
                // Write to an unmapped address must leave the fallback alone
                reg_write(UNMAPPED_ADDR, $urandom);
                reg_check(FALLBACK_ADDR);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                enqueue_snapshot(random_snapshot());
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (smoothed_due.size() != 0) begin
            report_error($sformatf("%0d results never arrived", smoothed_due.size()));
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
src/wps_pkg.sv
src/wps_ram.sv
src/windowed_parameter_smoother_unit.sv
tb/tb.sv
